// ===== rtl/cblp_pkg.sv =====
// Shared types and constants of the binary CAN log object parser.
package cblp_pkg;

    // File and object signatures, first byte in the low bits.
    localparam logic [31:0] FILE_SIG = 32'h0046_4C42;
    localparam logic [31:0] OBJ_SIG  = 32'h4A42_4F4C;

    // Object types that are decoded.
    localparam logic [31:0] TYPE_CAN   = 32'd1;
    localparam logic [31:0] TYPE_CANFD = 32'd86;

    // Layout limits.
    localparam int unsigned OBJ_HDR_BYTES     = 24;
    localparam int unsigned CAN_MIN_PAYLOAD   = 16;
    localparam int unsigned FD_MIN_PAYLOAD    = 76;
    localparam int unsigned MAX_PAYLOAD_BYTES = 64;
    // The payload memory always spans the eight data words of the largest payload.
    localparam int unsigned PAY_ROWS          = 8;
    localparam int unsigned ROW_W             = 3;

    // Result kinds.
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FILE_SIG  = 3'd1;
    localparam logic [2:0] ST_SHORT_HDR = 3'd2;
    localparam logic [2:0] ST_STATS     = 3'd3;
    localparam logic [2:0] ST_OBJ_SIG   = 3'd4;
    localparam logic [2:0] ST_OBJ_SIZE  = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;
    localparam logic [2:0] ST_NO_FRAMES = 3'd7;

    // Decoded frame header fields.
    typedef struct packed {
        logic [63:0] time_ns;
        logic        is_tx;
        logic        is_extended;
        logic        is_brs;
        logic        is_fd;
        logic [3:0]  dlc_code;
        logic [7:0]  channel_num;
        logic [28:0] can_id;
    } t_frame;

    // What one accepted byte produces, from the parser to the sequencer.
    typedef struct packed {
        logic       frame;
        logic       stat;
        logic [2:0] code;
        t_frame     f;
    } t_event;

    // One result as it travels on the output tdata, lowest field last.
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] data_word;
        t_frame      f;
    } t_result;

endpackage

// ===== rtl/cblp_parser.sv =====
// Byte-level parser state and the payload memory of the CAN log parser.
module cblp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    input  logic                          i_eof,
    input  logic [cblp_pkg::ROW_W-1:0]    i_rd_row,
    output logic [63:0]                   o_rd_data,
    output cblp_pkg::t_event              o_evt
);

    typedef enum logic [2:0] {PH_FSIG, PH_FHDR, PH_STATS, PH_OHDR, PH_OBODY} t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_off, n_off;
    logic [31:0] r_stats, n_stats;
    logic [15:0] r_hs, n_hs;
    logic [31:0] r_osz, n_osz;
    logic [31:0] r_otype, n_otype;
    logic [63:0] r_tick, n_tick;
    logic        r_sg, n_sg;
    logic [31:0] r_raw_id, n_raw_id;
    logic [15:0] r_raw_ch, n_raw_ch;
    logic [7:0]  r_raw_dlc, n_raw_dlc;
    logic [7:0]  r_raw_flags, n_raw_flags;
    logic        r_seen, n_seen;
    logic        r_halted, n_halted;

    // Payload memory: one row holds one data word, written a byte at a time.
    logic [63:0] r_mem [cblp_pkg::PAY_ROWS];
    logic [63:0] r_rd;

    logic [31:0] off1, rel, payload;
    logic        cls, fd, fin, err;
    logic [2:0]  err_code, eof_code;
    logic        w_en;
    logic [5:0]  w_idx;

    always_comb begin
        n_phase     = r_phase;
        n_off       = r_off;
        n_stats     = r_stats;
        n_hs        = r_hs;
        n_osz       = r_osz;
        n_otype     = r_otype;
        n_tick      = r_tick;
        n_sg        = r_sg;
        n_raw_id    = r_raw_id;
        n_raw_ch    = r_raw_ch;
        n_raw_dlc   = r_raw_dlc;
        n_raw_flags = r_raw_flags;
        n_seen      = r_seen;
        n_halted    = r_halted;
        fin         = 1'b0;
        err         = 1'b0;
        err_code    = cblp_pkg::ST_OK;
        eof_code    = cblp_pkg::ST_OK;
        w_en        = 1'b0;
        w_idx       = '0;
        off1        = r_off + 32'd1;
        rel         = r_off - {16'd0, r_hs};
        payload     = r_osz - {16'd0, r_hs};
        cls = (r_otype == cblp_pkg::TYPE_CAN) && (payload >= 32'(cblp_pkg::CAN_MIN_PAYLOAD));
        fd  = (r_otype == cblp_pkg::TYPE_CANFD) && (payload >= 32'(cblp_pkg::FD_MIN_PAYLOAD));

        if (i_accept && !r_halted) begin
            case (r_phase)
                PH_FSIG: begin
                    if (i_byte != cblp_pkg::FILE_SIG[8*r_off[1:0] +: 8]) begin
                        n_sg = 1'b0;
                    end
                    n_off = off1;
                    if (off1 >= 32'd4) begin
                        if (!n_sg) begin
                            err      = 1'b1;
                            err_code = cblp_pkg::ST_FILE_SIG;
                        end else begin
                            n_phase = PH_FHDR;
                        end
                    end
                end
                PH_FHDR: begin
                    if (r_off < 32'd8) begin
                        n_stats[8*r_off[1:0] +: 8] = i_byte;
                    end
                    n_off = off1;
                    if (off1 >= 32'd12) begin
                        if (n_stats < 32'(cblp_pkg::OBJ_HDR_BYTES)) begin
                            err      = 1'b1;
                            err_code = cblp_pkg::ST_STATS;
                        end else begin
                            n_phase = PH_STATS;
                        end
                    end
                end
                PH_STATS: begin
                    n_off = off1;
                    if (off1 >= r_stats) begin
                        n_phase = PH_OHDR;
                        n_off   = '0;
                    end
                end
                PH_OHDR: begin
                    // The first header byte opens a new object.
                    if (r_off == 32'd0) begin
                        n_sg        = 1'b1;
                        n_hs        = '0;
                        n_osz       = '0;
                        n_otype     = '0;
                        n_tick      = '0;
                        n_raw_id    = '0;
                        n_raw_ch    = '0;
                        n_raw_dlc   = '0;
                        n_raw_flags = '0;
                    end
                    if (r_off < 32'd4) begin
                        if (i_byte != cblp_pkg::OBJ_SIG[8*r_off[1:0] +: 8]) begin
                            n_sg = 1'b0;
                        end
                    end else if (r_off < 32'd6) begin
                        n_hs[8*r_off[0] +: 8] = i_byte;
                    end else if (r_off >= 32'd8 && r_off < 32'd12) begin
                        n_osz[8*r_off[1:0] +: 8] = i_byte;
                    end else if (r_off >= 32'd12 && r_off < 32'd16) begin
                        n_otype[8*r_off[1:0] +: 8] = i_byte;
                    end else if (r_off >= 32'd16 && r_off < 32'd24) begin
                        n_tick[8*r_off[2:0] +: 8] = i_byte;
                    end
                    n_off = off1;
                    if (off1 >= 32'(cblp_pkg::OBJ_HDR_BYTES)) begin
                        if (!n_sg) begin
                            err      = 1'b1;
                            err_code = cblp_pkg::ST_OBJ_SIG;
                        end else if (n_hs < 16'(cblp_pkg::OBJ_HDR_BYTES)
                                     || n_osz < {16'd0, n_hs}) begin
                            err      = 1'b1;
                            err_code = cblp_pkg::ST_OBJ_SIZE;
                        end else if (n_osz == 32'(cblp_pkg::OBJ_HDR_BYTES)) begin
                            // A bodiless object carries no frame.
                            n_off = '0;
                        end else begin
                            n_phase = PH_OBODY;
                        end
                    end
                end
                PH_OBODY: begin
                    if (r_off >= {16'd0, r_hs}) begin
                        if (rel < 32'd4) begin
                            n_raw_id[8*rel[1:0] +: 8] = i_byte;
                        end else if (rel < 32'd6) begin
                            n_raw_ch[8*rel[0] +: 8] = i_byte;
                        end else if (rel == 32'd6) begin
                            n_raw_dlc = i_byte;
                        end else if (rel == 32'd7) begin
                            n_raw_flags = i_byte;
                        end else if (r_otype == cblp_pkg::TYPE_CAN && rel < 32'd16) begin
                            w_en  = 1'b1;
                            w_idx = 6'(rel - 32'd8);
                        end else if (r_otype == cblp_pkg::TYPE_CANFD && rel >= 32'd12
                                     && rel < 32'd76) begin
                            if ((rel - 32'd12) < 32'(cblp_pkg::MAX_PAYLOAD_BYTES)) begin
                                w_en  = 1'b1;
                                w_idx = 6'(rel - 32'd12);
                            end
                        end
                    end
                    n_off = off1;
                    if (off1 >= r_osz) begin
                        fin     = 1'b1;
                        n_phase = PH_OHDR;
                        n_off   = '0;
                        if (cls || fd) begin
                            n_seen = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_FSIG;
                end
            endcase
        end

        if (err) begin
            n_halted = 1'b1;
        end

        // End-of-file status reflects the phase after this byte.
        case (n_phase)
            PH_FSIG:  eof_code = cblp_pkg::ST_FILE_SIG;
            PH_FHDR:  eof_code = cblp_pkg::ST_SHORT_HDR;
            PH_STATS: eof_code = cblp_pkg::ST_STATS;
            PH_OBODY: eof_code = cblp_pkg::ST_TRUNC;
            default:  eof_code = n_seen ? cblp_pkg::ST_OK : cblp_pkg::ST_NO_FRAMES;
        endcase

        // Event toward the result sequencer.
        o_evt.frame = fin && (cls || fd);
        o_evt.stat  = err || (i_accept && i_eof && !n_halted);
        o_evt.code  = err ? err_code : eof_code;
        o_evt.f.can_id = n_raw_id[28:0];
        if (n_raw_ch == 16'd0) begin
            o_evt.f.channel_num = 8'd1;
        end else if (n_raw_ch > 16'd255) begin
            o_evt.f.channel_num = 8'd255;
        end else begin
            o_evt.f.channel_num = n_raw_ch[7:0];
        end
        if (fd) begin
            o_evt.f.dlc_code = (n_raw_dlc > 8'd15) ? 4'd15 : n_raw_dlc[3:0];
        end else begin
            o_evt.f.dlc_code = (n_raw_dlc > 8'd8) ? 4'd8 : n_raw_dlc[3:0];
        end
        o_evt.f.is_fd       = fd;
        o_evt.f.is_brs      = fd && n_raw_flags[0];
        o_evt.f.is_extended = n_raw_flags[2];
        o_evt.f.is_tx       = n_raw_flags[4];
        o_evt.f.time_ns     = {r_tick[60:0], 3'b000} + {r_tick[62:0], 1'b0};

        // The end of a file returns the parser to its reset state.
        if (i_accept && i_eof) begin
            n_phase     = PH_FSIG;
            n_off       = '0;
            n_stats     = '0;
            n_hs        = '0;
            n_osz       = '0;
            n_otype     = '0;
            n_tick      = '0;
            n_sg        = 1'b1;
            n_raw_id    = '0;
            n_raw_ch    = '0;
            n_raw_dlc   = '0;
            n_raw_flags = '0;
            n_seen      = 1'b0;
            n_halted    = 1'b0;
        end
    end

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FSIG;
            r_off       <= '0;
            r_stats     <= '0;
            r_hs        <= '0;
            r_osz       <= '0;
            r_otype     <= '0;
            r_tick      <= '0;
            r_sg        <= 1'b1;
            r_raw_id    <= '0;
            r_raw_ch    <= '0;
            r_raw_dlc   <= '0;
            r_raw_flags <= '0;
            r_seen      <= 1'b0;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_off       <= n_off;
            r_stats     <= n_stats;
            r_hs        <= n_hs;
            r_osz       <= n_osz;
            r_otype     <= n_otype;
            r_tick      <= n_tick;
            r_sg        <= n_sg;
            r_raw_id    <= n_raw_id;
            r_raw_ch    <= n_raw_ch;
            r_raw_dlc   <= n_raw_dlc;
            r_raw_flags <= n_raw_flags;
            r_seen      <= n_seen;
            r_halted    <= n_halted;
        end
    end

    // Payload memory with byte writes and a registered row read.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_idx[3 +: cblp_pkg::ROW_W]][8*w_idx[2:0] +: 8] <= i_byte;
        end
        r_rd <= r_mem[i_rd_row];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== rtl/can_binary_log_object_parser.sv =====
// Binary CAN log object parser: result sequencer and output register.
// Throughput: one file byte per cycle while no result is pending. A byte that raises a status
// holds the input until its status result is registered; a byte that ends a decoded object
// holds it until the frame header and its data words (one for classic, eight for CAN FD) are
// registered, plus its status if that byte also ends the file; output stalls extend the holds.
// A status result or a frame header passes through the sequencer state to the output register.
// Reset: synchronous, active low; clears the parser and sequencer, not the payload memory.
module can_binary_log_object_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [7:0]    i_s_axis_tdata,   // file_byte
    input  logic          i_s_axis_tlast,   // end_of_file
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [175:0]  o_m_axis_tdata,   // can_id, channel_num, dlc_code, is_fd, is_brs,
                                            // is_extended, is_tx, time_ns, data_word, status
    output logic [1:0]    o_m_axis_tuser,   // kind
    output logic          o_m_axis_tlast    // last
);

    typedef enum logic [1:0] {SQ_RUN, SQ_HDR, SQ_WORD, SQ_STAT} t_seq;

    t_seq                      r_seq;
    cblp_pkg::t_frame          r_frame;
    logic [2:0]                r_word;
    logic [2:0]                r_nlast;
    logic                      r_eof_pend;
    logic [2:0]                r_code;
    logic                      r_ovalid;
    cblp_pkg::t_result         r_odata;
    logic [1:0]                r_okind;
    logic                      r_olast;

    logic                      accept, slot;
    logic [cblp_pkg::ROW_W-1:0] rd_row;
    logic [63:0]               rd_data;
    logic [63:0]               word_data;
    cblp_pkg::t_event          evt;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign slot   = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_seq == SQ_RUN);

    // Row to read so that the next data word is ready when it is sent.
    always_comb begin
        case (r_seq)
            SQ_WORD: rd_row = cblp_pkg::ROW_W'(slot ? r_word + 3'd1 : r_word);
            default: rd_row = '0;
        endcase
    end

    // Payload bytes at or beyond the payload limit read as zero.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (7'({r_word, 3'(k)}) < 7'(cblp_pkg::MAX_PAYLOAD_BYTES)) begin
                word_data[8*k +: 8] = rd_data[8*k +: 8];
            end else begin
                word_data[8*k +: 8] = 8'd0;
            end
        end
    end

    cblp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_s_axis_tdata),
        .i_eof     (i_s_axis_tlast),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data),
        .o_evt     (evt)
    );

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= SQ_RUN;
            r_ovalid   <= 1'b0;
            r_word     <= '0;
            r_nlast    <= '0;
            r_eof_pend <= 1'b0;
            r_code     <= cblp_pkg::ST_OK;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_seq)
                SQ_RUN: begin
                    if (accept && evt.frame) begin
                        r_seq      <= SQ_HDR;
                        r_frame    <= evt.f;
                        r_nlast    <= evt.f.is_fd ? 3'd7 : 3'd0;
                        r_eof_pend <= evt.stat;
                        r_code     <= evt.code;
                    end else if (accept && evt.stat) begin
                        r_seq  <= SQ_STAT;
                        r_code <= evt.code;
                    end
                end
                SQ_HDR: begin
                    if (slot) begin
                        r_ovalid          <= 1'b1;
                        r_okind           <= cblp_pkg::KIND_HDR;
                        r_olast           <= 1'b0;
                        r_odata.status    <= cblp_pkg::ST_OK;
                        r_odata.data_word <= '0;
                        r_odata.f         <= r_frame;
                        r_word            <= '0;
                        r_seq             <= SQ_WORD;
                    end
                end
                SQ_WORD: begin
                    if (slot) begin
                        r_ovalid          <= 1'b1;
                        r_okind           <= cblp_pkg::KIND_WORD;
                        r_olast           <= (r_word == r_nlast) && !r_eof_pend;
                        r_odata.status    <= cblp_pkg::ST_OK;
                        r_odata.data_word <= word_data;
                        r_odata.f         <= '0;
                        r_word            <= r_word + 3'd1;
                        if (r_word == r_nlast) begin
                            r_seq <= r_eof_pend ? SQ_STAT : SQ_RUN;
                        end
                    end
                end
                SQ_STAT: begin
                    if (slot) begin
                        r_ovalid          <= 1'b1;
                        r_okind           <= cblp_pkg::KIND_STAT;
                        r_olast           <= 1'b1;
                        r_odata.status    <= r_code;
                        r_odata.data_word <= '0;
                        r_odata.f         <= '0;
                        r_seq             <= SQ_RUN;
                    end
                end
                default: begin
                    r_seq <= SQ_RUN;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the binary CAN log object parser.
`timescale 1ns / 100ps

// Tracks expected parser results and checks the output stream against them.
class log_parse_board;
    typedef enum logic [2:0] {
        PH_FSIG, PH_FHDR, PH_STATS, PH_OHDR, PH_OBODY
    } t_phase;

    typedef struct {
        logic [1:0]       kind;
        cblp_pkg::t_result r;
        bit               last;
    } t_expect;

    t_expect pending_results[$];
    int unsigned errors;
    int unsigned frames_seen;
    int unsigned results_seen;

    t_phase      phase;
    bit [31:0]   offset;
    bit [31:0]   stats_size;
    bit [15:0]   hdr_size;
    bit [31:0]   obj_size;
    bit [31:0]   obj_type;
    bit [63:0]   ticks;
    bit          sig_ok;
    bit [31:0]   raw_id;
    bit [15:0]   raw_chan;
    bit [7:0]    raw_dlc;
    bit [7:0]    raw_flags;
    bit [7:0]    payload [64];
    bit          frame_done;
    bit          halted;
    t_expect     step_out[$];

    function new();
        errors = 0;
        frames_seen = 0;
        results_seen = 0;
        clear();
    endfunction

    function void clear();
        phase = PH_FSIG;
        offset = 0;
        stats_size = 0;
        hdr_size = 0;
        obj_size = 0;
        obj_type = 0;
        ticks = 0;
        sig_ok = 1;
        raw_id = 0;
        raw_chan = 0;
        raw_dlc = 0;
        raw_flags = 0;
        frame_done = 0;
        halted = 0;
    endfunction

    function void push_status(logic [2:0] code);
        t_expect e;
        e.kind = cblp_pkg::KIND_STAT;
        e.r = '0;
        e.r.status = code;
        e.last = 0;
        step_out.push_back(e);
    endfunction

    function void raise_error(logic [2:0] code);
        push_status(code);
        halted = 1;
    endfunction

    // Emits the frame header and its data words when the object decodes.
    function void finish_object();
        bit [31:0] pay_len;
        bit        classic;
        bit        fd;
        int        words;
        t_expect   e;
        bit [63:0] v;
        pay_len = obj_size - 32'(hdr_size);
        classic = (obj_type == cblp_pkg::TYPE_CAN) && (pay_len >= cblp_pkg::CAN_MIN_PAYLOAD);
        fd = (obj_type == cblp_pkg::TYPE_CANFD) && (pay_len >= cblp_pkg::FD_MIN_PAYLOAD);
        if (!classic && !fd) return;
        e.kind = cblp_pkg::KIND_HDR;
        e.r = '0;
        e.last = 0;
        e.r.f.can_id = raw_id[28:0];
        e.r.f.channel_num = (raw_chan == 0) ? 8'd1 : (raw_chan > 255) ? 8'd255 : raw_chan[7:0];
        if (classic) e.r.f.dlc_code = (raw_dlc > 8) ? 4'd8 : raw_dlc[3:0];
        else e.r.f.dlc_code = (raw_dlc > 15) ? 4'd15 : raw_dlc[3:0];
        e.r.f.is_fd = fd;
        e.r.f.is_brs = fd && raw_flags[0];
        e.r.f.is_extended = raw_flags[2];
        e.r.f.is_tx = raw_flags[4];
        e.r.f.time_ns = ticks * 64'd10;
        step_out.push_back(e);
        words = fd ? 8 : 1;
        for (int w = 0; w < words; w++) begin
            v = 0;
            for (int k = 0; k < 8; k++)
                v[8*k +: 8] = (w*8 + k < cblp_pkg::MAX_PAYLOAD_BYTES) ? payload[w*8 + k] : 8'd0;
            e.kind = cblp_pkg::KIND_WORD;
            e.r = '0;
            e.r.data_word = v;
            step_out.push_back(e);
        end
        frame_done = 1;
        frames_seen++;
    endfunction

    // Captures identifier, channel, DLC, flags and payload from the body.
    function void capture_body(bit [7:0] b, bit [31:0] rel);
        if (rel < 4) raw_id[8*rel +: 8] = b;
        else if (rel < 6) raw_chan[8*(rel-4) +: 8] = b;
        else if (rel == 6) raw_dlc = b;
        else if (rel == 7) raw_flags = b;
        else if (obj_type == cblp_pkg::TYPE_CAN && rel < 16) payload[(rel-8) & 63] = b;
        else if (obj_type == cblp_pkg::TYPE_CANFD && rel >= 12 && rel < 76) begin
            if (rel - 12 < cblp_pkg::MAX_PAYLOAD_BYTES) payload[rel-12] = b;
        end
    endfunction

    function void parse_byte(bit [7:0] b);
        bit [31:0] off;
        off = offset;
        case (phase)
            PH_FSIG: begin
                if (b != cblp_pkg::FILE_SIG[8*off[1:0] +: 8]) sig_ok = 0;
                offset = off + 1;
                if (offset >= 4) begin
                    if (!sig_ok) raise_error(cblp_pkg::ST_FILE_SIG);
                    else phase = PH_FHDR;
                end
            end
            PH_FHDR: begin
                if (off < 8) stats_size[8*(off-4) +: 8] = b;
                offset = off + 1;
                if (offset >= 12) begin
                    if (stats_size < 24) raise_error(cblp_pkg::ST_STATS);
                    else phase = PH_STATS;
                end
            end
            PH_STATS: begin
                offset = off + 1;
                if (offset >= stats_size) begin
                    phase = PH_OHDR;
                    offset = 0;
                end
            end
            PH_OHDR: begin
                if (off == 0) begin
                    sig_ok = 1;
                    hdr_size = 0;
                    obj_size = 0;
                    obj_type = 0;
                    ticks = 0;
                    raw_id = 0;
                    raw_chan = 0;
                    raw_dlc = 0;
                    raw_flags = 0;
                end
                if (off < 4) begin
                    if (b != cblp_pkg::OBJ_SIG[8*off +: 8]) sig_ok = 0;
                end else if (off < 6) hdr_size[8*(off-4) +: 8] = b;
                else if (off >= 8 && off < 12) obj_size[8*(off-8) +: 8] = b;
                else if (off >= 12 && off < 16) obj_type[8*(off-12) +: 8] = b;
                else if (off >= 16 && off < 24) ticks[8*(off-16) +: 8] = b;
                offset = off + 1;
                if (offset >= 24) begin
                    if (!sig_ok) raise_error(cblp_pkg::ST_OBJ_SIG);
                    else if (hdr_size < 24 || obj_size < 32'(hdr_size))
                        raise_error(cblp_pkg::ST_OBJ_SIZE);
                    else if (obj_size == 24) begin
                        finish_object();
                        offset = 0;
                    end else phase = PH_OBODY;
                end
            end
            default: begin
                if (off >= 32'(hdr_size)) capture_body(b, off - 32'(hdr_size));
                offset = off + 1;
                if (offset >= obj_size) begin
                    finish_object();
                    phase = PH_OHDR;
                    offset = 0;
                end
            end
        endcase
    endfunction

    // Notes one accepted file byte and queues what it should produce.
    function void note_byte(bit [7:0] b, bit eof);
        step_out.delete();
        if (!halted) parse_byte(b);
        if (eof) begin
            if (!halted) begin
                case (phase)
                    PH_FSIG:  push_status(cblp_pkg::ST_FILE_SIG);
                    PH_FHDR:  push_status(cblp_pkg::ST_SHORT_HDR);
                    PH_STATS: push_status(cblp_pkg::ST_STATS);
                    PH_OBODY: push_status(cblp_pkg::ST_TRUNC);
                    default:  push_status(frame_done ? cblp_pkg::ST_OK : cblp_pkg::ST_NO_FRAMES);
                endcase
            end
            clear();
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
        foreach (step_out[i]) pending_results.push_back(step_out[i]);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // Checks one accepted result against the oldest expectation.
    function void check_result(logic [1:0] kind, cblp_pkg::t_result r, logic last);
        t_expect e;
        results_seen++;
        if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d status %0d", kind, r.status);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        cmp("kind", e.kind, kind);
        cmp("last", e.last, last);
        cmp("can_id", e.r.f.can_id, r.f.can_id);
        cmp("channel_num", e.r.f.channel_num, r.f.channel_num);
        cmp("dlc_code", e.r.f.dlc_code, r.f.dlc_code);
        cmp("is_fd", e.r.f.is_fd, r.f.is_fd);
        cmp("is_brs", e.r.f.is_brs, r.f.is_brs);
        cmp("is_extended", e.r.f.is_extended, r.f.is_extended);
        cmp("is_tx", e.r.f.is_tx, r.f.is_tx);
        cmp("time_ns", e.r.f.time_ns, r.f.time_ns);
        cmp("data_word", e.r.data_word, r.data_word);
        cmp("status", e.r.status, r.status);
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [7:0]    i_s_axis_tdata;
    logic          i_s_axis_tlast;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic [175:0]  o_m_axis_tdata;
    logic [1:0]    o_m_axis_tuser;
    logic          o_m_axis_tlast;

    log_parse_board board;
    bit [7:0]    file_bytes[$];
    int unsigned bytes_sent;
    int unsigned files_sent;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          quiet_mode;

    can_binary_log_object_parser uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tlast(i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser),
        .o_m_axis_tlast(o_m_axis_tlast)
    );

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: random stalls on tready, checks at the rising edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tuser, cblp_pkg::t_result'(o_m_axis_tdata),
                               o_m_axis_tlast);
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL can_binary_log_object_parser");
                $finish;
            end
        end
    end

    // Sends one byte: optional gap, then holds the request until accepted.
    task automatic send_byte(bit [7:0] b, bit eof);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = b;
        i_s_axis_tlast = eof;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        board.note_byte(b, eof);
        bytes_sent++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
        file_bytes.delete();
    endtask

    task automatic put_le(bit [63:0] v, int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_file_head(bit [31:0] stats);
        put_le(cblp_pkg::FILE_SIG, 4);
        put_le(stats, 4);
        put_le({$urandom, $urandom}, 4);
        for (int i = 12; i < stats; i++) file_bytes.push_back(8'($urandom));
    endtask

    // Appends one object: 0 classic, 1 FD, 2 other type, 3 short payload, 4 header only.
    task automatic put_object(int form);
        bit [15:0] hsize;
        int        body;
        bit [31:0] otype;
        bit [63:0] tk;
        bit [15:0] chan;
        bit [7:0]  dlc;
        hsize = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(25, 32)) : 16'd24;
        case (form)
            0: begin otype = cblp_pkg::TYPE_CAN;   body = 16 + $urandom_range(0, 4); end
            1: begin otype = cblp_pkg::TYPE_CANFD; body = 76 + $urandom_range(0, 4); end
            2: begin otype = $urandom_range(2, 85);  body = $urandom_range(1, 20); end
            3: begin
                otype = $urandom_range(0, 1) ? cblp_pkg::TYPE_CAN : cblp_pkg::TYPE_CANFD;
                body = (otype == cblp_pkg::TYPE_CAN) ? $urandom_range(1, 15) : $urandom_range(1, 75);
            end
            default: begin otype = cblp_pkg::TYPE_CAN; body = 0; hsize = 24; end
        endcase
        tk = ($urandom_range(0, 5) == 0) ? '1 : {$urandom, $urandom};
        put_le(cblp_pkg::OBJ_SIG, 4);
        put_le(hsize, 2);
        put_le($urandom, 2);
        put_le(32'(hsize) + body, 4);
        put_le(otype, 4);
        put_le(tk, 8);
        for (int i = 24; i < hsize; i++) file_bytes.push_back(8'($urandom));
        case ($urandom_range(0, 3))
            0: chan = 0;
            1: chan = 16'($urandom);
            default: chan = 16'($urandom_range(1, 8));
        endcase
        dlc = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 15));
        for (int i = 0; i < body; i++) begin
            if (i < 4) file_bytes.push_back(($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom));
            else if (i < 6) file_bytes.push_back(chan[8*(i-4) +: 8]);
            else if (i == 6) file_bytes.push_back(dlc);
            else file_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic drain_results();
        while (board.pending_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int objs;
        int cut;
        board = new();
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b0;
        bytes_sent = 0;
        files_sent = 0;
        idle_cycles = 0;
        stall_left = 0;
        quiet_mode = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: end of file inside the file signature.
        file_bytes = '{8'h42};
        send_file();
        // Bad file signature; bytes after it are ignored until end of file.
        file_bytes = '{8'h42, 8'h4C, 8'h58, 8'h00, 8'hFF, 8'h00};
        send_file();
        // End of file inside the file header.
        file_bytes = '{8'h42, 8'h4C, 8'h46, 8'h00, 8'h18, 8'h00};
        send_file();
        // Statistics size of 23 is rejected.
        put_le(cblp_pkg::FILE_SIG, 4);
        put_le(32'd23, 4);
        put_le(32'hFFFF_FFFF, 4);
        send_file();
        // Minimum statistics block and no objects: no frames status.
        put_file_head(32'd24);
        send_file();
        // End of file inside the statistics block.
        put_file_head(32'd30);
        void'(file_bytes.pop_back());
        send_file();
        // One FD and one classic frame in a clean file.
        put_file_head(32'd24);
        put_object(1);
        put_object(0);
        send_file();

        // Random files: mostly well formed, some corrupted or truncated.
        while (bytes_sent < 460) begin
            quiet_mode = ($urandom_range(0, 3) == 0);
            if (files_sent == 7) drain_results();
            put_file_head($urandom_range(0, 3) == 0 ? $urandom_range(25, 40) : 24);
            objs = $urandom_range(0, 3);
            for (int k = 0; k < objs; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: put_object(0);
                    4, 5, 6:    put_object(1);
                    7:          put_object(2);
                    8:          put_object(3);
                    default:    put_object(4);
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
            send_file();
        end
        quiet_mode = 0;

        drain_results();
        repeat (30) @(negedge i_clk);
        $display("Sent %0d files, %0d bytes; checked %0d results, %0d decoded frames.",
                 files_sent, bytes_sent, board.results_seen, board.frames_seen);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("PASS can_binary_log_object_parser");
        else
            $display("FAIL can_binary_log_object_parser");
        $finish;
    end
endmodule
